/* sv/dhvt_pkg.sv */
// Shared constants and codes for the double-hash versioned table.
`timescale 1ns / 1ps
`default_nettype none
package dhvt_pkg;
   localparam int MAX_SLOTS_DEF = 64;
   localparam int KEY_W         = 31;
   localparam int REL_W         = 16;
   localparam int HND_W         = 16;
   localparam int FUNC_W        = 2;
   localparam int SLOT_W        = 6;
   localparam int CSR_W         = 7;
   localparam logic [KEY_W-1:0] STRIDE_MIX = KEY_W'(1155345);
   localparam logic [REL_W-1:0] REL_MAX    = '1;

   // operation codes
   localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FN_FIND   = 2'd2;

   // slot status codes
   localparam logic [1:0] ST_FREE    = 2'd0;
   localparam logic [1:0] ST_BUSY    = 2'd1;
   localparam logic [1:0] ST_DELETED = 2'd2;
endpackage
`default_nettype wire

/* sv/double_hash_versioned_table_unit.sv */
// Top level: open-addressed versioned hash table with double hashing.
//
// Input channel req_* (valid/ready) carries one operation: insert, remove or
// find. Result channel rsp_* (valid/ready) returns one result per insert,
// remove or unknown operation, and one result per match for find (last set
// on the final one, or a single not-found result).
// Steps: reduce the key to home slot and stride in a bit-serial remainder
// unit, then per probed slot a memory read and an evaluate/write back, then
// present the final result. At most slots_in_use slots are probed. One item
// is in work at a time; the next is taken once the final result has entered
// the output register, even while that result still waits for the receiver.
// Reset empties the table (all slots free, via per-slot valid bits, no
// clearing pass), zeroes the entry count and sets slots_in_use to 64.
// When the receiver stalls, the result holds in the output register; find
// pauses its search until the register frees.
// csr_wr_data sets slots_in_use (0 acts as 1, above the table size acts as
// the table size); write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module double_hash_versioned_table_unit #(
   parameter int MAX_SLOTS = dhvt_pkg::MAX_SLOTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [dhvt_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [dhvt_pkg::KEY_W-1:0]    req_key,
   input  wire logic [dhvt_pkg::REL_W-1:0]    req_release_wanted,
   input  wire logic [dhvt_pkg::HND_W-1:0]    req_item_handle,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_ok,
   output logic [dhvt_pkg::SLOT_W-1:0]        rsp_slot_index,
   output logic [dhvt_pkg::REL_W-1:0]         rsp_release_out,
   output logic [dhvt_pkg::HND_W-1:0]         rsp_handle_out,
   output logic                               rsp_last,
   input  wire logic                          csr_wr_en,
   input  wire logic [dhvt_pkg::CSR_W-1:0]    csr_wr_data
);
   localparam int IW = $clog2(MAX_SLOTS);
   localparam int NW = $clog2(MAX_SLOTS+1);
   localparam int DW = dhvt_pkg::KEY_W + dhvt_pkg::REL_W + dhvt_pkg::HND_W;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DIV  = 5'b00010,
      S_RD   = 5'b00100,
      S_EV   = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   logic [dhvt_pkg::CSR_W-1:0]   csr_ff;
   logic [NW-1:0]                span_now;
   logic [NW-1:0]                n_ff, n_in;
   logic [NW-1:0]                ecnt_ff, ecnt_in;
   logic [NW-1:0]                pcnt_ff, pcnt_in;
   logic [dhvt_pkg::FUNC_W-1:0]  func_ff, func_in;
   logic [dhvt_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [dhvt_pkg::REL_W-1:0]   relw_ff, relw_in;
   logic [dhvt_pkg::HND_W-1:0]   hnd_ff, hnd_in;
   logic [IW-1:0]                idx_ff, idx_in, home_ff, home_in, strd_ff, strd_in;
   logic [dhvt_pkg::REL_W-1:0]   best_ff, best_in;
   logic                         pend_ff, pend_in;
   logic [IW-1:0]                pslot_ff, pslot_in;
   logic [dhvt_pkg::REL_W-1:0]   prel_ff, prel_in;
   logic [dhvt_pkg::HND_W-1:0]   phnd_ff, phnd_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_ok_ff, rsp_ok_in, rsp_last_ff, rsp_last_in;
   logic [IW-1:0]                rsp_slot_ff, rsp_slot_in;
   logic [dhvt_pkg::REL_W-1:0]   rsp_rel_ff, rsp_rel_in;
   logic [dhvt_pkg::HND_W-1:0]   rsp_hnd_ff, rsp_hnd_in;

   // slot store: status with per-slot valid bits, and key/release/handle
   logic [1:0]                   stat_mem [MAX_SLOTS];
   logic [DW-1:0]                dat_mem  [MAX_SLOTS];
   logic [MAX_SLOTS-1:0]         svld_ff;
   logic [1:0]                   rd_stat_ff;
   logic                         rd_vld_ff;
   logic [DW-1:0]                rd_dat_ff;
   logic                         rd_en, st_we, dat_we;
   logic [1:0]                   st_wdata;

   logic                         div_start, div_done;
   logic [IW-1:0]                div_home, div_stride;

   logic                         accept, out_free, push;
   logic [1:0]                   cur_stat;
   logic [dhvt_pkg::KEY_W-1:0]   cur_key;
   logic [dhvt_pkg::REL_W-1:0]   cur_rel;
   logic [dhvt_pkg::HND_W-1:0]   cur_hnd;
   logic                         is_busy, is_free, is_match, last_probe, stall;
   logic [IW:0]                  step_sum;
   logic [IW-1:0]                idx_next;
   logic [dhvt_pkg::REL_W-1:0]   new_rel;

   // reduction starts on the accepting edge, so it takes the key from the port
   dhvt_mod_unit #(.MAX_SLOTS(MAX_SLOTS)) u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .key    (req_key),
      .span   (n_ff),
      .done   (div_done),
      .home   (div_home),
      .stride (div_stride)
   );

   // effective slot count from the register
   always_comb begin
      if (csr_ff == '0)
         span_now = NW'(1);
      else if (csr_ff > dhvt_pkg::CSR_W'(MAX_SLOTS))
         span_now = NW'(MAX_SLOTS);
      else
         span_now = NW'(csr_ff);
   end

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // decode of the slot just read
   assign cur_stat = rd_vld_ff ? rd_stat_ff : dhvt_pkg::ST_FREE;
   assign {cur_key, cur_rel, cur_hnd} = rd_dat_ff;
   assign is_busy  = (cur_stat == dhvt_pkg::ST_BUSY);
   assign is_free  = (cur_stat == dhvt_pkg::ST_FREE);
   assign is_match = is_busy && (cur_key == key_ff) &&
                     ((relw_ff == '0) || (cur_rel == relw_ff));
   assign step_sum = {1'b0, idx_ff} + {1'b0, strd_ff};
   assign idx_next = (step_sum >= (IW+1)'(n_ff)) ? IW'(step_sum - (IW+1)'(n_ff))
                                                 : IW'(step_sum);
   assign last_probe = ((pcnt_ff + NW'(1)) == n_ff);
   assign new_rel  = (best_ff == dhvt_pkg::REL_MAX) ? best_ff : best_ff + 1'b1;
   assign stall    = (func_ff == dhvt_pkg::FN_FIND) && is_match && pend_ff && !out_free;

   // sequencer: reduce, then read / evaluate each probed slot
   always_comb begin
      state_in = state_ff;
      n_in = n_ff; ecnt_in = ecnt_ff; pcnt_in = pcnt_ff;
      func_in = func_ff; key_in = key_ff; relw_in = relw_ff; hnd_in = hnd_ff;
      idx_in = idx_ff; home_in = home_ff; strd_in = strd_ff; best_in = best_ff;
      pend_in = pend_ff; pslot_in = pslot_ff; prel_in = prel_ff; phnd_in = phnd_ff;
      div_start = 1'b0;
      rd_en = 1'b0; st_we = 1'b0; dat_we = 1'b0; st_wdata = dhvt_pkg::ST_BUSY;
      push = 1'b0;
      rsp_ok_in = rsp_ok_ff; rsp_last_in = rsp_last_ff; rsp_slot_in = rsp_slot_ff;
      rsp_rel_in = rsp_rel_ff; rsp_hnd_in = rsp_hnd_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in = req_func; key_in = req_key;
               relw_in = req_release_wanted; hnd_in = req_item_handle;
               n_in = span_now; pend_in = 1'b0; best_in = '0; pcnt_in = '0;
               if (req_func == dhvt_pkg::FN_INSERT && ecnt_ff >= span_now)
                  state_in = S_DONE;
               else if (req_func == dhvt_pkg::FN_INSERT ||
                        req_func == dhvt_pkg::FN_REMOVE ||
                        req_func == dhvt_pkg::FN_FIND)
                  state_in = S_DIV;
               else
                  state_in = S_DONE;
               div_start = (state_in == S_DIV);
            end
         end
         S_DIV: begin
            if (div_done) begin
               home_in = div_home; strd_in = div_stride; idx_in = div_home;
               state_in = S_RD;
            end
         end
         S_RD: begin
            rd_en = 1'b1;
            state_in = S_EV;
         end
         S_EV: begin
            if (!stall) begin
               state_in = S_RD;
               idx_in = idx_next;
               pcnt_in = pcnt_ff + NW'(1);
               if (func_ff == dhvt_pkg::FN_INSERT) begin
                  if (!is_busy) begin
                     st_we = 1'b1; dat_we = 1'b1; st_wdata = dhvt_pkg::ST_BUSY;
                     pend_in = 1'b1; pslot_in = idx_ff; prel_in = new_rel;
                     phnd_in = hnd_ff; ecnt_in = ecnt_ff + NW'(1);
                     state_in = S_DONE;
                  end else begin
                     if (cur_key == key_ff && cur_rel > best_ff)
                        best_in = cur_rel;
                     if (last_probe)
                        state_in = S_DONE;
                  end
               end else begin
                  if (is_free) begin
                     state_in = S_DONE;
                  end else begin
                     if (is_match) begin
                        if (func_ff == dhvt_pkg::FN_REMOVE) begin
                           st_we = 1'b1; st_wdata = dhvt_pkg::ST_DELETED;
                           pend_in = 1'b1;
                           if (ecnt_ff != '0)
                              ecnt_in = ecnt_ff - NW'(1);
                        end else begin
                           // earlier match goes out, not last
                           if (pend_ff) begin
                              push = 1'b1;
                              rsp_ok_in = 1'b1; rsp_last_in = 1'b0;
                              rsp_slot_in = pslot_ff; rsp_rel_in = prel_ff;
                              rsp_hnd_in = phnd_ff;
                           end
                           pend_in = 1'b1; pslot_in = idx_ff;
                           prel_in = cur_rel; phnd_in = cur_hnd;
                        end
                     end
                     if ((is_match && relw_ff != '0) || idx_next == home_ff || last_probe)
                        state_in = S_DONE;
                  end
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               push = 1'b1;
               rsp_ok_in = pend_ff; rsp_last_in = 1'b1;
               if (pend_ff && func_ff != dhvt_pkg::FN_REMOVE) begin
                  rsp_slot_in = pslot_ff; rsp_rel_in = prel_ff; rsp_hnd_in = phnd_ff;
               end else begin
                  rsp_slot_in = '0; rsp_rel_in = '0; rsp_hnd_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = push ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         csr_ff       <= dhvt_pkg::CSR_W'(64);
         ecnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         svld_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         ecnt_ff      <= ecnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en)
            csr_ff <= csr_wr_data;
         if (st_we)
            svld_ff[idx_ff] <= 1'b1;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      n_ff <= n_in; pcnt_ff <= pcnt_in;
      func_ff <= func_in; key_ff <= key_in; relw_ff <= relw_in; hnd_ff <= hnd_in;
      idx_ff <= idx_in; home_ff <= home_in; strd_ff <= strd_in; best_ff <= best_in;
      pend_ff <= pend_in; pslot_ff <= pslot_in; prel_ff <= prel_in; phnd_ff <= phnd_in;
      rsp_ok_ff <= rsp_ok_in; rsp_last_ff <= rsp_last_in; rsp_slot_ff <= rsp_slot_in;
      rsp_rel_ff <= rsp_rel_in; rsp_hnd_ff <= rsp_hnd_in;
   end

   // slot memories, registered read
   always_ff @(posedge clock) begin
      if (st_we)
         stat_mem[idx_ff] <= st_wdata;
      if (dat_we)
         dat_mem[idx_ff] <= {key_ff, new_rel, hnd_ff};
      if (rd_en) begin
         rd_stat_ff <= stat_mem[idx_ff];
         rd_dat_ff  <= dat_mem[idx_ff];
         rd_vld_ff  <= svld_ff[idx_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_slot_index  = dhvt_pkg::SLOT_W'(rsp_slot_ff);
   assign rsp_release_out = rsp_rel_ff;
   assign rsp_handle_out  = rsp_hnd_ff;
   assign rsp_last        = rsp_last_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ecnt_ff <= NW'(MAX_SLOTS))
      else $error("entry count beyond table size");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result written over an untaken result");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second item taken while one is in work");
endmodule
`default_nettype wire

/* sv/dhvt_mod_unit.sv */
// Bit-serial remainder unit: home and stride of a key, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none
module dhvt_mod_unit #(
   parameter int MAX_SLOTS = dhvt_pkg::MAX_SLOTS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [dhvt_pkg::KEY_W-1:0]           key,
   input  wire logic [$clog2(MAX_SLOTS+1)-1:0]       span,
   output logic                                      done,
   output logic [$clog2(MAX_SLOTS)-1:0]              home,
   output logic [$clog2(MAX_SLOTS)-1:0]              stride
);
   localparam int IW = $clog2(MAX_SLOTS);
   localparam int NW = $clog2(MAX_SLOTS+1);
   localparam int CW = $clog2(dhvt_pkg::KEY_W+1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [dhvt_pkg::KEY_W-1:0]  ka_ff, ka_in, kb_ff, kb_in;
   logic [NW-1:0]               ra_ff, ra_in, rb_ff, rb_in;
   logic [NW:0]                 ra_sh, rb_sh, span_x;

   // shift one dividend bit into each remainder, subtract once if needed
   always_comb begin
      span_x  = (NW+1)'(span);
      ra_sh   = {ra_ff, ka_ff[dhvt_pkg::KEY_W-1]};
      rb_sh   = {rb_ff, kb_ff[dhvt_pkg::KEY_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ka_in   = ka_ff;
      kb_in   = kb_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(dhvt_pkg::KEY_W);
         ka_in   = key;
         kb_in   = key ^ dhvt_pkg::STRIDE_MIX;
         ra_in   = '0;
         rb_in   = '0;
      end else if (busy_ff) begin
         ra_in  = (ra_sh >= span_x) ? NW'(ra_sh - span_x) : NW'(ra_sh);
         rb_in  = (rb_sh >= span_x) ? NW'(rb_sh - span_x) : NW'(rb_sh);
         ka_in  = ka_ff << 1;
         kb_in  = kb_ff << 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ka_ff <= ka_in;
      kb_ff <= kb_in;
      ra_ff <= ra_in;
      rb_ff <= rb_in;
   end

   assign done   = done_ff;
   assign home   = IW'(ra_ff);
   assign stride = (rb_ff == '0) ? IW'(1) : IW'(rb_ff);
endmodule
`default_nettype wire
